/* src/dbts_pkg.sv */
// ----------------------------------------------------------------------------
// dbts_pkg
// Shared types, codes and widths for the debounced edge timestamp capture.
// ----------------------------------------------------------------------------
package dbts_pkg;

  localparam int unsigned DEF_MAX_INPUTS  = 16;
  localparam int unsigned DEF_QUEUE_DEPTH = 64;

  localparam int unsigned TICK_W    = 32;
  localparam int unsigned INDEX_W   = 8;
  localparam int unsigned ACTIVE_W  = 5;
  localparam int unsigned QLEN_W    = 7;
  localparam int unsigned SLOT_IN_W = 4;
  localparam int unsigned CFG_AW    = 4;
  localparam int unsigned CFG_DW    = 32;

  typedef enum logic [1:0] {
    ACT_PIN_CHANGE = 2'd0,
    ACT_POP        = 2'd1,
    ACT_CLR_TIMERS = 2'd2,
    ACT_CLR_QUEUE  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_SAME      = 3'd1,
    ST_DEBOUNCED = 3'd2,
    ST_BAD_INDEX = 3'd3,
    ST_OVERRUN   = 3'd4,
    ST_POPPED    = 3'd5,
    ST_EMPTY     = 3'd6,
    ST_CLEARED   = 3'd7
  } status_e;

  typedef enum logic [2:0] {
    CH_BAD_INDEX = 3'd0,
    CH_SAME      = 3'd1,
    CH_BOUNCE    = 3'd2,
    CH_FALL      = 3'd3,
    CH_RISE      = 3'd4
  } chan_kind_e;

  typedef enum logic [1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_ACTIVE   = 2'd1,
    REG_QLEN     = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [1:0]         action;
    logic [INDEX_W-1:0] input_index;
    logic               level;
    logic [TICK_W-1:0]  low_tick;
    logic [TICK_W-1:0]  high_tick;
  } in_item_t;

  typedef struct packed {
    status_e              status;
    logic [SLOT_IN_W-1:0] event_input;
    logic [TICK_W-1:0]    event_low_tick;
    logic [TICK_W-1:0]    event_low_prev;
    logic [TICK_W-1:0]    event_high_tick;
    logic [TICK_W-1:0]    event_high_prev;
    logic                 first_lap;
    logic [TICK_W-1:0]    overrun_total;
  } out_item_t;

  typedef struct packed {
    logic [TICK_W-1:0]   debounce_ticks;
    logic [ACTIVE_W-1:0] active_inputs;
    logic [QLEN_W-1:0]   queue_length;
  } cfg_t;

  // One queued rising edge.
  typedef struct packed {
    logic [SLOT_IN_W-1:0] input_id;
    logic [TICK_W-1:0]    low_tick;
    logic [TICK_W-1:0]    low_prev;
    logic [TICK_W-1:0]    high_tick;
    logic [TICK_W-1:0]    high_prev;
  } slot_t;

  typedef struct packed {
    chan_kind_e        kind;
    logic [TICK_W-1:0] low_prev;
    logic [TICK_W-1:0] high_prev;
  } chan_res_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic clr;
  } queue_op_t;

  typedef struct packed {
    logic              overrun;
    logic              popped;
    logic [TICK_W-1:0] overrun_next;
  } queue_stat_t;

endpackage

/* src/debounced_edge_timestamp_capture.sv */
// ----------------------------------------------------------------------------
// debounced_edge_timestamp_capture
// Takes one transaction per clock unless stalled: a pin change, a pop of the
// oldest queued rising edge, a timer clear or a queue clear, and returns one
// result for each. A transaction is registered on entry, checked against the
// per-input state and the ring queue combinationally, and moved from the entry
// register to the result register; a new one can enter every cycle while the
// result register is empty or draining and no pointer reduction runs. Writing
// queue_length starts a pointer reduction against the new length, one quotient
// bit per cycle, that holds off input until it is done. Changes are debounced
// on the low-resolution tick, and results carry the input index, not a pin.
// ----------------------------------------------------------------------------
module debounced_edge_timestamp_capture import dbts_pkg::*; #(
  parameter int unsigned MAX_INPUTS  = DEF_MAX_INPUTS,
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_item_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  cfg_t               cfg;
  logic               qlen_wr;
  logic               busy;

  logic               s1_valid_q;
  in_item_t           s1_item_q;
  logic               out_valid_q;
  status_e            out_status_q;
  logic [TICK_W-1:0]  out_ovf_q;

  logic               advance;
  action_e            act;
  logic [INDEX_W-1:0] eff_inputs;
  chan_res_t          chan_res;
  queue_op_t          qop;
  queue_stat_t        qstat;
  slot_t              wdata;
  slot_t              rdata;
  status_e            status;

  dbts_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cfg_o     (cfg),
    .qlen_wr_o (qlen_wr)
  );

  assign act        = action_e'(s1_item_q.action);
  assign advance    = s1_valid_q && !busy && (!out_valid_q || !out_stall_i);
  assign in_stall_o = busy || (s1_valid_q && !advance);

  assign eff_inputs = (INDEX_W'(cfg.active_inputs) > INDEX_W'(MAX_INPUTS)) ?
                      INDEX_W'(MAX_INPUTS) : INDEX_W'(cfg.active_inputs);

  dbts_chan #(
    .MAX_INPUTS (MAX_INPUTS)
  ) u_chan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .upd_i        (advance && act == ACT_PIN_CHANGE),
    .clr_i        (advance && act == ACT_CLR_TIMERS),
    .item_i       (s1_item_q),
    .eff_inputs_i (eff_inputs),
    .debounce_i   (cfg.debounce_ticks),
    .res_o        (chan_res)
  );

  assign qop.push = (act == ACT_PIN_CHANGE) && (chan_res.kind == CH_RISE);
  assign qop.pop  = (act == ACT_POP);
  assign qop.clr  = (act == ACT_CLR_QUEUE);

  assign wdata.input_id  = s1_item_q.input_index[SLOT_IN_W-1:0];
  assign wdata.low_tick  = s1_item_q.low_tick;
  assign wdata.low_prev  = chan_res.low_prev;
  assign wdata.high_tick = s1_item_q.high_tick;
  assign wdata.high_prev = chan_res.high_prev;

  dbts_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .qlen_i    (cfg.queue_length),
    .qlen_wr_i (qlen_wr),
    .busy_o    (busy),
    .fire_i    (advance),
    .op_i      (qop),
    .wdata_i   (wdata),
    .stat_o    (qstat),
    .rdata_o   (rdata)
  );

  always_comb begin
    case (act)
      ACT_PIN_CHANGE: begin
        case (chan_res.kind)
          CH_BAD_INDEX: status = ST_BAD_INDEX;
          CH_SAME:      status = ST_SAME;
          CH_BOUNCE:    status = ST_DEBOUNCED;
          CH_RISE:      status = qstat.overrun ? ST_OVERRUN : ST_ACCEPTED;
          default:      status = ST_ACCEPTED;
        endcase
      end
      ACT_POP: status = qstat.popped ? ST_POPPED : ST_EMPTY;
      default: status = ST_CLEARED;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      s1_item_q <= in_item_i;
    end
    if (advance) begin
      out_status_q <= status;
      out_ovf_q    <= qstat.overrun_next;
    end
  end

  // Event fields come from the slot read that was registered alongside the
  // status; they are shown only for a successful pop.
  always_comb begin
    out_item_o               = '0;
    out_item_o.status        = out_status_q;
    out_item_o.overrun_total = out_ovf_q;
    if (out_status_q == ST_POPPED) begin
      out_item_o.event_input     = rdata.input_id;
      out_item_o.event_low_tick  = rdata.low_tick;
      out_item_o.event_low_prev  = rdata.low_prev;
      out_item_o.event_high_tick = rdata.high_tick;
      out_item_o.event_high_prev = rdata.high_prev;
      out_item_o.first_lap       = (rdata.low_prev == '0);
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* src/dbts_cfg.sv */
// ----------------------------------------------------------------------------
// dbts_cfg
// APB register file: debounce interval, active input count, queue length.
// ----------------------------------------------------------------------------
module dbts_cfg import dbts_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o,
  output logic              qlen_wr_o
);

  cfg_t     cfg_q;
  logic     qlen_wr_q;
  logic     wr_en;
  reg_idx_e reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[CFG_AW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q     <= '0;
      qlen_wr_q <= 1'b0;
    end else begin
      qlen_wr_q <= 1'b0;
      if (wr_en) begin
        case (reg_idx)
          REG_DEBOUNCE: cfg_q.debounce_ticks <= pwdata;
          REG_ACTIVE:   cfg_q.active_inputs  <= pwdata[ACTIVE_W-1:0];
          REG_QLEN: begin
            cfg_q.queue_length <= pwdata[QLEN_W-1:0];
            qlen_wr_q          <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DEBOUNCE: prdata = cfg_q.debounce_ticks;
      REG_ACTIVE:   prdata = CFG_DW'(cfg_q.active_inputs);
      REG_QLEN:     prdata = CFG_DW'(cfg_q.queue_length);
      default:      prdata = '0;
    endcase
  end

  assign cfg_o     = cfg_q;
  assign qlen_wr_o = qlen_wr_q;

endmodule

/* src/dbts_chan.sv */
// ----------------------------------------------------------------------------
// dbts_chan
// Per-input level and timestamp state with the debounce decision.
// ----------------------------------------------------------------------------
module dbts_chan import dbts_pkg::*; #(
  parameter int unsigned MAX_INPUTS = DEF_MAX_INPUTS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               upd_i,
  input  logic               clr_i,
  input  in_item_t           item_i,
  input  logic [INDEX_W-1:0] eff_inputs_i,
  input  logic [TICK_W-1:0]  debounce_i,
  output chan_res_t          res_o
);

  localparam int unsigned IDX_W = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;

  logic              level_q     [MAX_INPUTS];
  logic [TICK_W-1:0] change_q    [MAX_INPUTS];
  logic [TICK_W-1:0] rise_low_q  [MAX_INPUTS];
  logic [TICK_W-1:0] rise_high_q [MAX_INPUTS];

  logic [IDX_W-1:0]  idx;
  logic              in_range;
  logic [TICK_W-1:0] gap;
  logic              bounce;
  chan_kind_e        kind;

  assign idx      = item_i.input_index[IDX_W-1:0];
  assign in_range = item_i.input_index < eff_inputs_i;
  // Wrapping difference since the last accepted change of this input.
  assign gap      = item_i.low_tick - change_q[idx];
  assign bounce   = (debounce_i != '0) && (gap < debounce_i);

  always_comb begin
    if (!in_range) begin
      kind = CH_BAD_INDEX;
    end else if (item_i.level == level_q[idx]) begin
      kind = CH_SAME;
    end else if (bounce) begin
      kind = CH_BOUNCE;
    end else if (item_i.level) begin
      kind = CH_RISE;
    end else begin
      kind = CH_FALL;
    end
  end

  assign res_o.kind      = kind;
  assign res_o.low_prev  = rise_low_q[idx];
  assign res_o.high_prev = rise_high_q[idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_INPUTS; i++) begin
        level_q[i]     <= 1'b0;
        change_q[i]    <= '0;
        rise_low_q[i]  <= '0;
        rise_high_q[i] <= '0;
      end
    end else if (clr_i) begin
      for (int i = 0; i < MAX_INPUTS; i++) begin
        if (INDEX_W'(i) < eff_inputs_i) begin
          level_q[i]     <= 1'b0;
          change_q[i]    <= '0;
          rise_low_q[i]  <= '0;
          rise_high_q[i] <= '0;
        end
      end
    end else if (upd_i && (kind == CH_RISE || kind == CH_FALL)) begin
      level_q[idx]  <= item_i.level;
      change_q[idx] <= item_i.low_tick;
      if (kind == CH_RISE) begin
        rise_low_q[idx]  <= item_i.low_tick;
        rise_high_q[idx] <= item_i.high_tick;
      end
    end
  end

endmodule

/* src/dbts_queue.sv */
// ----------------------------------------------------------------------------
// dbts_queue
// Ring queue of rising-edge events: pending flags, pointers, slot memory and
// the overrun counter.
// ----------------------------------------------------------------------------
module dbts_queue import dbts_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [QLEN_W-1:0] qlen_i,
  input  logic              qlen_wr_i,
  output logic              busy_o,
  input  logic              fire_i,
  input  queue_op_t         op_i,
  input  slot_t             wdata_i,
  output queue_stat_t       stat_o,
  output slot_t             rdata_o
);

  localparam int unsigned PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned EXT_W  = (CNT_W > QLEN_W) ? CNT_W : QLEN_W;
  localparam int unsigned SW     = (CNT_W > PTR_W) ? CNT_W : PTR_W;
  localparam int unsigned STEP_W = (PTR_W > 1) ? $clog2(PTR_W) : 1;

  slot_t                   mem_q [QUEUE_DEPTH];
  slot_t                   rdata_q;
  logic [QUEUE_DEPTH-1:0]  pend_q;
  logic [PTR_W-1:0]        wr_raw_q, rd_raw_q;
  logic [PTR_W-1:0]        wr_mod_q, rd_mod_q;
  logic [TICK_W-1:0]       ovf_q;
  logic                    busy_q;
  logic [STEP_W-1:0]       step_q;

  logic [EXT_W-1:0]        qlen_ext;
  logic [CNT_W-1:0]        q_eff;
  logic                    q_none;
  logic [CNT_W-1:0]        wr_inc, rd_inc;
  logic [PTR_W-1:0]        wr_next, rd_next;
  logic                    overrun, do_push, popped;
  logic [PTR_W-1:0]        wr_red, rd_red;

  assign qlen_ext = EXT_W'(qlen_i);
  assign q_eff    = (qlen_ext > EXT_W'(QUEUE_DEPTH)) ? CNT_W'(QUEUE_DEPTH) : CNT_W'(qlen_ext);
  assign q_none   = (q_eff == '0);

  assign wr_inc  = CNT_W'(wr_mod_q) + CNT_W'(1);
  assign rd_inc  = CNT_W'(rd_mod_q) + CNT_W'(1);
  assign wr_next = (wr_inc == q_eff) ? '0 : wr_inc[PTR_W-1:0];
  assign rd_next = (rd_inc == q_eff) ? '0 : rd_inc[PTR_W-1:0];

  assign overrun = op_i.push && !q_none && pend_q[wr_mod_q];
  assign do_push = op_i.push && !q_none && !pend_q[wr_mod_q];
  assign popped  = op_i.pop && !q_none && pend_q[rd_mod_q];

  // One restoring step of pointer % queue length. The subtrahend is only
  // taken when it fits below the pointer, so truncating it is lossless.
  always_comb begin
    wr_red = wr_mod_q;
    rd_red = rd_mod_q;
    if (SW'(wr_mod_q >> step_q) >= SW'(q_eff)) begin
      wr_red = wr_mod_q - (PTR_W'(q_eff) << step_q);
    end
    if (SW'(rd_mod_q >> step_q) >= SW'(q_eff)) begin
      rd_red = rd_mod_q - (PTR_W'(q_eff) << step_q);
    end
  end

  assign busy_o = busy_q || qlen_wr_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= '0;
      wr_raw_q <= '0;
      rd_raw_q <= '0;
      wr_mod_q <= '0;
      rd_mod_q <= '0;
      ovf_q    <= '0;
      busy_q   <= 1'b0;
      step_q   <= '0;
    end else if (qlen_wr_i) begin
      // The stored pointers are kept as written; the working copies are
      // reduced against the new length before the next transaction.
      wr_mod_q <= wr_raw_q;
      rd_mod_q <= rd_raw_q;
      busy_q   <= 1'b1;
      step_q   <= STEP_W'(PTR_W - 1);
    end else if (busy_q) begin
      wr_mod_q <= wr_red;
      rd_mod_q <= rd_red;
      if (step_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        step_q <= step_q - STEP_W'(1);
      end
    end else if (fire_i) begin
      if (op_i.clr) begin
        pend_q   <= '0;
        wr_raw_q <= '0;
        rd_raw_q <= '0;
        wr_mod_q <= '0;
        rd_mod_q <= '0;
      end
      if (do_push) begin
        pend_q[wr_mod_q] <= 1'b1;
        wr_raw_q         <= wr_next;
        wr_mod_q         <= wr_next;
      end
      if (popped) begin
        pend_q[rd_mod_q] <= 1'b0;
        rd_raw_q         <= rd_next;
        rd_mod_q         <= rd_next;
      end
      if (overrun) begin
        ovf_q <= ovf_q + TICK_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && do_push) begin
      mem_q[wr_mod_q] <= wdata_i;
    end
    if (fire_i) begin
      rdata_q <= mem_q[rd_mod_q];
    end
  end

  assign stat_o.overrun      = overrun;
  assign stat_o.popped       = popped;
  assign stat_o.overrun_next = overrun ? ovf_q + TICK_W'(1) : ovf_q;
  assign rdata_o             = rdata_q;

  a_no_fire_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !fire_i)
    else $error("transaction processed during pointer reduction");

  a_ptr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy_q && !qlen_wr_i && !q_none) |->
      (CNT_W'(wr_mod_q) < q_eff && CNT_W'(rd_mod_q) < q_eff))
    else $error("queue pointer outside the active length");

  a_pop_frees_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && !busy_o && popped) |=> !pend_q[$past(rd_mod_q)])
    else $error("popped slot still pending");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && !busy_o && op_i.clr) |=>
      (pend_q == '0 && wr_raw_q == '0 && rd_raw_q == '0))
    else $error("queue clear left state behind");

endmodule
